FILE: rtl/glpf_pkg.sv
// Shared constants and types for the grid local peak finder.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
package glpf_pkg;

    localparam int MAX_COLS   = 32;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int PIXEL_BITS = 16;
    localparam int ROW_W      = 10;
    localparam int ROWS_REG_W = 11;
    localparam int COLS_REG_W = 6;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS = CFG_ADDR_W'(1);

    localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RESET = ROWS_REG_W'(20);
    localparam logic [COLS_REG_W-1:0] GRID_COLS_RESET = COLS_REG_W'(20);
    localparam logic [ROWS_REG_W-1:0] ROWS_MIN        = ROWS_REG_W'(2);
    localparam logic [ROWS_REG_W-1:0] ROWS_MAX        = ROWS_REG_W'(1024);
    localparam logic [COLS_REG_W-1:0] COLS_MIN        = COLS_REG_W'(2);
    localparam logic [COLS_REG_W-1:0] COLS_MAX        = COLS_REG_W'(MAX_COLS);

    // Per-cell control: global strobes plus the cell's place in the row.
    typedef struct packed {
        logic shift;       // pixel transaction: advance both line chains
        logic capture;     // latch the last-row peak flag
        logic flag_shift;  // move flags one cell toward cell 0
        logic tail;        // this cell is the last column of the row
        logic active;      // this cell lies inside the row
        logic has_left;    // a left neighbor exists
    } t_cell_ctl;

endpackage

FILE: rtl/glpf_if.sv
// Stream interfaces for the grid local peak finder: pixel in, peak out,
// register writes. Depends on glpf_pkg for field widths.
interface glpf_pix_if;
    logic                             valid;
    logic                             ready;
    logic [glpf_pkg::PIXEL_BITS-1:0]  pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface glpf_peak_if;
    logic                        valid;
    logic                        ready;
    logic [glpf_pkg::ROW_W-1:0]  peak_row;
    logic [glpf_pkg::COL_W-1:0]  peak_col;
    logic                        last;
    modport source (output valid, output peak_row, output peak_col, output last, input ready);
    modport sink   (input valid, input peak_row, input peak_col, input last, output ready);
endinterface

interface glpf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [glpf_pkg::CFG_ADDR_W-1:0]  addr;
    logic [glpf_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/glpf_cell.sv
// One column cell: a tap of the current-row and previous-row delay lines
// plus the last-row peak flag. Depends on glpf_pkg.
module glpf_cell (
    input  logic                            i_clk,
    input  glpf_pkg::t_cell_ctl             i_ctl,
    input  logic [glpf_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic [glpf_pkg::PIXEL_BITS-1:0] i_l1_feed,
    input  logic [glpf_pkg::PIXEL_BITS-1:0] i_l1_left,
    input  logic [glpf_pkg::PIXEL_BITS-1:0] i_l1_right,
    input  logic [glpf_pkg::PIXEL_BITS-1:0] i_l2_right,
    input  logic                            i_flag_right,
    output logic [glpf_pkg::PIXEL_BITS-1:0] o_l1,
    output logic [glpf_pkg::PIXEL_BITS-1:0] o_l2,
    output logic                            o_flag
);

    logic [glpf_pkg::PIXEL_BITS-1:0] r_l1;
    logic [glpf_pkg::PIXEL_BITS-1:0] r_l2;
    logic                            r_flag;
    logic                            w_peak;

    // Last row sits in l1, the row above it in l2; the bottom edge has no neighbor.
    assign w_peak = (r_l1 >= r_l2)
                 && (!i_ctl.has_left || r_l1 >= i_l1_left)
                 && (i_ctl.tail || r_l1 >= i_l1_right);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_l1 <= i_ctl.tail ? i_pixel : i_l1_right;
            r_l2 <= i_ctl.tail ? i_l1_feed : i_l2_right;
        end
        if (i_ctl.capture) begin
            r_flag <= i_ctl.active && w_peak;
        end else if (i_ctl.flag_shift) begin
            r_flag <= i_flag_right;
        end
    end

    assign o_l1   = r_l1;
    assign o_l2   = r_l2;
    assign o_flag = r_flag;

endmodule

FILE: rtl/grid_local_peak_finder.sv
// Grid local peak finder top level: row of column cells plus control.
// Depends on glpf_pkg, glpf_if (interfaces) and glpf_cell.
//
// Usage:
//   i_pix  carries the frame's pixels in raster order, one per transaction.
//   o_peak carries (row, col) of each cell that is >= its existing up, down,
//          left and right neighbors, in raster order; last marks the final
//          result caused by one pixel.
//   i_cfg  writes grid_rows (address 0) and grid_cols (address 1); a
//          write to either restarts the frame. Write only while the block is idle.
// Throughput: one pixel per cycle while o_peak keeps up. Pixel (r,c) with
//   r >= 1 settles cell (r-1,c), whose result is presented on the cycle
//   after the transaction; the frame's last pixel's result is held until
//   S_HEAD. After the frame's last pixel the block stops taking pixels
//   while it captures the last row's flags in the cells and walks them out
//   one column a cycle, pausing while o_peak stalls on a flagged column.
// Reset: grid 20 x 20, position (0,0), no result pending. Line contents
//   are undefined until written and are never read before that.
// Stall: a single output register holds the pending result; while it is
//   full and not taken, i_pix.ready stays low.
module grid_local_peak_finder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    glpf_pix_if.sink        i_pix,
    glpf_peak_if.source     o_peak,
    glpf_cfg_if.sink        i_cfg
);

    typedef enum logic [1:0] {S_RUN, S_CAPT, S_HEAD, S_SCAN} t_state;

    localparam int PB = glpf_pkg::PIXEL_BITS;
    localparam int CW = glpf_pkg::COL_W;
    localparam int RW = glpf_pkg::ROW_W;
    localparam int NC = glpf_pkg::MAX_COLS;

    t_state                             r_state, n_state;
    logic [RW-1:0]                      r_row, n_row;
    logic [CW-1:0]                      r_col, n_col;
    logic [CW-1:0]                      r_scan, n_scan;
    logic [glpf_pkg::ROWS_REG_W-1:0]    r_grid_rows, n_grid_rows;
    logic [glpf_pkg::COLS_REG_W-1:0]    r_grid_cols, n_grid_cols;
    logic                               r_hold_valid, n_hold_valid;
    logic                               r_out_valid, n_out_valid;
    logic [RW-1:0]                      r_hold_row, n_hold_row;
    logic [CW-1:0]                      r_hold_col, n_hold_col;
    logic [RW-1:0]                      r_out_row, n_out_row;
    logic [CW-1:0]                      r_out_col, n_out_col;
    logic                               r_out_last, n_out_last;
    logic [PB-1:0]                      r_prev, n_prev;

    logic [glpf_pkg::ROWS_REG_W-1:0]    w_rows_eff, w_rows_m1;
    logic [glpf_pkg::COLS_REG_W-1:0]    w_cols_eff, w_cols_m1;
    logic [RW-1:0]                      w_last_row;
    logic [CW-1:0]                      w_last_col;
    logic [RW-1:0]                      w_row_use;
    logic [CW-1:0]                      w_col_use;
    logic                               w_pix_acc, w_cfg_acc, w_out_free;
    logic                               w_frame_end, w_peak, w_scan_adv;
    logic                               w_flag_rest;

    logic [PB-1:0]                      w_l1   [NC];
    logic [PB-1:0]                      w_l2   [NC];
    logic [NC-1:0]                      w_flag;
    glpf_pkg::t_cell_ctl                w_ctl  [NC];

    // Clamp the registers to their usable ranges.
    always_comb begin
        if (r_grid_rows < glpf_pkg::ROWS_MIN) begin
            w_rows_eff = glpf_pkg::ROWS_MIN;
        end else if (r_grid_rows > glpf_pkg::ROWS_MAX) begin
            w_rows_eff = glpf_pkg::ROWS_MAX;
        end else begin
            w_rows_eff = r_grid_rows;
        end
        if (r_grid_cols < glpf_pkg::COLS_MIN) begin
            w_cols_eff = glpf_pkg::COLS_MIN;
        end else if (r_grid_cols > glpf_pkg::COLS_MAX) begin
            w_cols_eff = glpf_pkg::COLS_MAX;
        end else begin
            w_cols_eff = r_grid_cols;
        end
    end

    assign w_rows_m1  = w_rows_eff - glpf_pkg::ROWS_REG_W'(1);
    assign w_cols_m1  = w_cols_eff - glpf_pkg::COLS_REG_W'(1);
    assign w_last_row = w_rows_m1[RW-1:0];
    assign w_last_col = w_cols_m1[CW-1:0];
    assign w_row_use  = (r_row > w_last_row) ? '0 : r_row;
    assign w_col_use  = (r_col > w_last_col) ? '0 : r_col;

    assign w_out_free  = !r_out_valid || o_peak.ready;
    assign i_pix.ready = (r_state == S_RUN) && w_out_free;
    assign i_cfg.ready = 1'b1;
    assign w_pix_acc   = i_pix.valid && i_pix.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_frame_end = (w_row_use == w_last_row) && (w_col_use == w_last_col);
    assign w_scan_adv  = (r_state == S_SCAN) && (!w_flag[0] || w_out_free);
    assign w_flag_rest = |w_flag[NC-1:1];

    // Cell (r-1,c): above in l2 cell 0, below is the incoming pixel,
    // left in r_prev (l1 cell 0 at the previous transaction), right in l1 cell 1.
    assign w_peak = (w_row_use != '0)
                 && (w_row_use < RW'(2) || w_l1[0] >= w_l2[0])
                 && (w_l1[0] >= i_pix.pixel)
                 && (w_col_use == '0 || w_l1[0] >= r_prev)
                 && (w_col_use == w_last_col || w_l1[0] >= w_l1[1]);

    genvar k;
    generate
        for (k = 0; k < NC; k++) begin : g_cell
            logic [PB-1:0] w_left, w_l1_right, w_l2_right;
            logic          w_flag_right;

            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_l1[k-1];
            end
            if (k == NC - 1) begin : g_end
                assign w_l1_right   = '0;
                assign w_l2_right   = '0;
                assign w_flag_right = 1'b0;
            end else begin : g_inner
                assign w_l1_right   = w_l1[k+1];
                assign w_l2_right   = w_l2[k+1];
                assign w_flag_right = w_flag[k+1];
            end

            assign w_ctl[k].shift      = w_pix_acc;
            assign w_ctl[k].capture    = (r_state == S_CAPT);
            assign w_ctl[k].flag_shift = w_scan_adv;
            assign w_ctl[k].tail       = (CW'(k) == w_last_col);
            assign w_ctl[k].active     = (CW'(k) <= w_last_col);
            assign w_ctl[k].has_left   = (k != 0);

            glpf_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[k]),
                .i_pixel      (i_pix.pixel),
                .i_l1_feed    (w_l1[0]),
                .i_l1_left    (w_left),
                .i_l1_right   (w_l1_right),
                .i_l2_right   (w_l2_right),
                .i_flag_right (w_flag_right),
                .o_l1         (w_l1[k]),
                .o_l2         (w_l2[k]),
                .o_flag       (w_flag[k])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_scan       = r_scan;
        n_grid_rows  = r_grid_rows;
        n_grid_cols  = r_grid_cols;
        n_hold_valid = r_hold_valid;
        n_hold_row   = r_hold_row;
        n_hold_col   = r_hold_col;
        n_prev       = r_prev;
        n_out_valid  = r_out_valid && !o_peak.ready;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;

        case (r_state)
            S_RUN: begin
                if (w_pix_acc) begin
                    n_prev = w_l1[0];
                    if (w_frame_end) begin
                        // hold this result until the last row's flags are known
                        n_hold_valid = w_peak;
                        n_hold_row   = w_row_use - RW'(1);
                        n_hold_col   = w_col_use;
                        n_state      = S_CAPT;
                    end else if (w_peak) begin
                        n_out_valid = 1'b1;
                        n_out_row   = w_row_use - RW'(1);
                        n_out_col   = w_col_use;
                        n_out_last  = 1'b1;
                    end
                    if (w_col_use == w_last_col) begin
                        n_col = '0;
                        n_row = (w_row_use == w_last_row) ? '0 : w_row_use + RW'(1);
                    end else begin
                        n_col = w_col_use + CW'(1);
                        n_row = w_row_use;
                    end
                end
            end
            S_CAPT: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (!r_hold_valid) begin
                    n_scan  = '0;
                    n_state = S_SCAN;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = r_hold_row;
                    n_out_col    = r_hold_col;
                    n_out_last   = !(|w_flag);
                    n_hold_valid = 1'b0;
                    n_scan       = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_adv) begin
                    if (w_flag[0]) begin
                        n_out_valid = 1'b1;
                        n_out_row   = w_last_row;
                        n_out_col   = r_scan;
                        n_out_last  = !w_flag_rest;
                    end
                    if (r_scan == w_last_col) begin
                        n_state = S_RUN;
                    end else begin
                        n_scan = r_scan + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        // Register write to a mapped address: store and restart the frame.
        if (w_cfg_acc) begin
            if (i_cfg.addr == glpf_pkg::CFG_GRID_ROWS) begin
                n_grid_rows = i_cfg.data[glpf_pkg::ROWS_REG_W-1:0];
                n_row       = '0;
                n_col       = '0;
            end else if (i_cfg.addr == glpf_pkg::CFG_GRID_COLS) begin
                n_grid_cols = i_cfg.data[glpf_pkg::COLS_REG_W-1:0];
                n_row       = '0;
                n_col       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_row        <= '0;
            r_col        <= '0;
            r_scan       <= '0;
            r_grid_rows  <= glpf_pkg::GRID_ROWS_RESET;
            r_grid_cols  <= glpf_pkg::GRID_COLS_RESET;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_scan       <= n_scan;
            r_grid_rows  <= n_grid_rows;
            r_grid_cols  <= n_grid_cols;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_hold_row <= n_hold_row;
        r_hold_col <= n_hold_col;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
        r_prev     <= n_prev;
    end

    assign o_peak.valid    = r_out_valid;
    assign o_peak.peak_row = r_out_row;
    assign o_peak.peak_col = r_out_col;
    assign o_peak.last     = r_out_last;

endmodule

FILE: bench/glpf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for grid_local_peak_finder: tracks register writes, predicts the
// peaks of each pixel transaction and compares them with the output stream.
// Depends on glpf_pkg and the stream interfaces in glpf_if.
module glpf_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    glpf_pix_if     pix,
    glpf_peak_if    peak,
    glpf_cfg_if     cfg,
    output int      o_fails,
    output int      o_pending
);
    import glpf_pkg::*;

    localparam int LINES     = 3;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_peak;

    t_peak                 peak_q[$];
    logic [PIXEL_BITS-1:0] line_mem [LINES][MAX_COLS];
    logic [ROWS_REG_W-1:0] rows_reg;
    logic [COLS_REG_W-1:0] cols_reg;
    int                    cur_row;
    int                    cur_col;
    int                    fails;

    function automatic int rows_used();
        if (rows_reg < ROWS_MIN) return ROWS_MIN;
        if (rows_reg > ROWS_MAX) return ROWS_MAX;
        return rows_reg;
    endfunction

    function automatic int cols_used();
        if (cols_reg < COLS_MIN) return COLS_MIN;
        if (cols_reg > COLS_MAX) return COLS_MAX;
        return cols_reg;
    endfunction

    function automatic bit is_local_max(int r, int c, int rows, int cols);
        logic [PIXEL_BITS-1:0] v;
        v = line_mem[r % LINES][c];
        if (r > 0 && v < line_mem[(r - 1) % LINES][c]) return 1'b0;
        if (r + 1 < rows && v < line_mem[(r + 1) % LINES][c]) return 1'b0;
        if (c > 0 && v < line_mem[r % LINES][c - 1]) return 1'b0;
        if (c + 1 < cols && v < line_mem[r % LINES][c + 1]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (fails < PRINT_CAP) $display("%0t: peak mismatch: %s", $time, what);
        fails++;
    endtask

    task automatic predict_peaks(input logic [PIXEL_BITS-1:0] value);
        int rows;
        int cols;
        int first;
        rows  = rows_used();
        cols  = cols_used();
        first = peak_q.size();
        if (cur_row >= rows) cur_row = 0;
        if (cur_col >= cols) cur_col = 0;
        line_mem[cur_row % LINES][cur_col] = value;
        // this pixel settles the cell right above it
        if (cur_row >= 1 && is_local_max(cur_row - 1, cur_col, rows, cols))
            peak_q.push_back(t_peak'{ROW_W'(cur_row - 1), COL_W'(cur_col), 1'b0});
        // the final pixel of the frame also settles the whole last row
        if (cur_row + 1 == rows && cur_col + 1 == cols) begin
            for (int cc = 0; cc < cols; cc++) begin
                if (is_local_max(cur_row, cc, rows, cols))
                    peak_q.push_back(t_peak'{ROW_W'(cur_row), COL_W'(cc), 1'b0});
            end
        end
        if (peak_q.size() > first) peak_q[peak_q.size() - 1].last = 1'b1;
        cur_col++;
        if (cur_col >= cols) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows) cur_row = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_peak want;
        if (!i_rst_n) begin
            peak_q.delete();
            rows_reg = GRID_ROWS_RESET;
            cols_reg = GRID_COLS_RESET;
            cur_row  = 0;
            cur_col  = 0;
            fails    = 0;
            for (int l = 0; l < LINES; l++)
                for (int c = 0; c < MAX_COLS; c++)
                    line_mem[l][c] = '0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    CFG_GRID_ROWS: begin
                        rows_reg = cfg.data[ROWS_REG_W-1:0];
                        cur_row  = 0;
                        cur_col  = 0;
                    end
                    CFG_GRID_COLS: begin
                        cols_reg = cfg.data[COLS_REG_W-1:0];
                        cur_row  = 0;
                        cur_col  = 0;
                    end
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) predict_peaks(pix.pixel);
            if (peak.valid && peak.ready) begin
                if (peak_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected peak (%0d,%0d)",
                                              peak.peak_row, peak.peak_col));
                end else begin
                    want = peak_q.pop_front();
                    if (peak.peak_row !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d",
                                                  peak.peak_row, want.row));
                    if (peak.peak_col !== want.col)
                        report_mismatch($sformatf("col %0d, want %0d at row %0d",
                                                  peak.peak_col, want.col, want.row));
                    if (peak.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b at (%0d,%0d)",
                                                  peak.last, want.last, want.row, want.col));
                end
            end
        end
        o_fails   <= fails;
        o_pending <= peak_q.size();
    end

endmodule

FILE: bench/tb_grid_local_peak_finder.sv
`timescale 1ns / 100ps
// Testbench top for grid_local_peak_finder: drives pixel and register traffic
// with random pacing and gives the verdict. Checking lives in glpf_checker.
module tb_grid_local_peak_finder;
    import glpf_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = '1;

    typedef enum {PIX_RANDOM, PIX_FEW_LEVELS, PIX_EXTREME, PIX_NEAR_TOP, PIX_MIXED}
        t_pix_style;

    logic i_clk;
    logic i_rst_n;
    int   fails;
    int   pending;
    int   burst_left;
    bit   steady_send;
    bit   hold_req;

    glpf_pix_if  pix_if ();
    glpf_peak_if peak_if ();
    glpf_cfg_if  cfg_if ();

    grid_local_peak_finder dut (
        .i_clk,
        .i_rst_n,
        .i_pix  (pix_if),
        .o_peak (peak_if),
        .i_cfg  (cfg_if)
    );

    glpf_checker peak_check (
        .i_clk,
        .i_rst_n,
        .pix       (pix_if),
        .peak      (peak_if),
        .cfg       (cfg_if),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: stall pattern that changes mode now and then, plus one long
    // hold-off whenever hold_req flips.
    initial begin
        int  hold_left;
        int  mode_left;
        int  mode;
        bit  hold_seen;
        bit  toggle;
        peak_if.ready = 1'b0;
        hold_left     = 0;
        mode_left     = 0;
        mode          = 0;
        hold_seen     = 1'b0;
        toggle        = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            toggle = !toggle;
            if (hold_left > 0) begin
                hold_left--;
                peak_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       peak_if.ready <= 1'b1;
                    1:       peak_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       peak_if.ready <= ($urandom_range(0, 3) == 0);
                    default: peak_if.ready <= toggle;
                endcase
            end
        end
    end

    // End the run when no transaction of any kind happens for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (peak_if.valid && peak_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(t_pix_style style);
        case (style)
            PIX_FEW_LEVELS: return PIXEL_BITS'($urandom_range(0, 2));
            PIX_EXTREME:    return $urandom_range(0, 1) ? '1 : '0;
            PIX_NEAR_TOP:   return PIXEL_BITS'($urandom_range(65533, 65535));
            default:        return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic int grid_area(int rows_raw, int cols_raw);
        int rows;
        int cols;
        rows = (rows_raw < ROWS_MIN) ? ROWS_MIN : (rows_raw > ROWS_MAX) ? ROWS_MAX : rows_raw;
        cols = (cols_raw < COLS_MIN) ? COLS_MIN : (cols_raw > COLS_MAX) ? COLS_MAX : cols_raw;
        return rows * cols;
    endfunction

    task automatic put_pixel(input logic [PIXEL_BITS-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = steady_send ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    task automatic send_pixels(input int count, input t_pix_style style);
        t_pix_style s;
        for (int i = 0; i < count; i++) begin
            s = (style == PIX_MIXED) ? t_pix_style'($urandom_range(0, 3)) : style;
            put_pixel(pick_pixel(s));
        end
    endtask

    // Drop valid, wait for every predicted peak, then let the row flush finish.
    task automatic drain_peaks();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper data bits above the column field are junk and must be ignored.
    task automatic set_grid(input int rows_raw, input int cols_raw);
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows_raw));
        write_reg(CFG_GRID_COLS, {(CFG_DATA_W - COLS_REG_W)'($urandom),
                                  COLS_REG_W'(cols_raw)});
    endtask

    task automatic run_grid(input int rows_raw, input int cols_raw, input int frames,
                            input int extra, input t_pix_style style);
        set_grid(rows_raw, cols_raw);
        steady_send = ($urandom_range(0, 3) == 0);
        send_pixels(frames * grid_area(rows_raw, cols_raw) + extra, style);
        drain_peaks();
    endtask

    initial begin
        int cols_raw;
        pix_if.valid  = 1'b0;
        pix_if.pixel  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.addr   = '0;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        hold_req      = 1'b0;
        burst_left    = 0;
        steady_send   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: a full 20-wide row and one more pixel.
        send_pixels(21, PIX_RANDOM);
        drain_peaks();

        // Below-range values act as 2 x 2; the open frame restarts.
        set_grid(0, 1);
        put_pixel('1);
        put_pixel('0);
        put_pixel('0);
        put_pixel('1);
        // Flat frame: every cell ties with its neighbors, so all are peaks.
        repeat (4) put_pixel(PIXEL_BITS'(16'h8000));
        // A write to an unmapped index must not restart the frame.
        send_pixels(2, PIX_RANDOM);
        drain_peaks();
        write_reg(CFG_UNMAPPED, '1);
        send_pixels(2, PIX_RANDOM);
        drain_peaks();

        // Long output hold-off while the sender keeps pushing a wide frame.
        set_grid(2, 63);
        steady_send = 1'b1;
        hold_req   <= !hold_req;
        send_pixels(grid_area(2, 63), PIX_MIXED);
        drain_peaks();

        run_grid(1, 0, 3, 1, PIX_FEW_LEVELS);
        run_grid(2, 2, 2, 0, PIX_EXTREME);
        run_grid(1025, 3, 0, 12, PIX_MIXED);
        repeat (2) begin
            cols_raw = $urandom_range(2, 6);
            run_grid($urandom_range(2, 4), cols_raw, 1,
                     $urandom_range(0, cols_raw), PIX_MIXED);
        end
        run_grid(20, 20, 0, 30, PIX_RANDOM);

        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
